### sv/rs2u_pkg.sv
// Shared types and constants for the radix string to uint64 converter.
`timescale 1ns / 1ps
package rs2u_pkg;

  localparam int VALUE_W     = 64;
  localparam int DIGIT_W     = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;

  // Configuration register indexes
  localparam logic [0:0] CFG_RADIX         = 1'b0;
  localparam logic [0:0] CFG_UNSIGNED_ONLY = 1'b1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] LETTER_BASE = 8'd10;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_CHAR  = 3'd1,
    ST_BAD_DIGIT = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    K_DIGIT,
    K_NUL,
    K_MINUS,
    K_PLUS,
    K_OTHER
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [DIGIT_W-1:0]  digit;
    logic                last;
  } item_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] radix;
    logic               unsigned_only;
  } cfg_t;

endpackage

### sv/rs2u_front.sv
// Front end: accepts characters and classifies them into queue items.
`timescale 1ns / 1ps
module rs2u_front (
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,   // [7:0] ch
  input  logic           in_tlast,
  input  logic           q_full,
  output logic           q_push,
  output rs2u_pkg::item_t q_item
);
  import rs2u_pkg::*;

  function automatic item_t classify(input logic [7:0] ch, input logic last);
    item_t it;
    it.last  = last;
    it.digit = '0;
    it.kind  = K_OTHER;
    if (ch == CH_NUL) begin
      it.kind = K_NUL;
    end else if (ch == CH_MINUS) begin
      it.kind = K_MINUS;
    end else if (ch == CH_PLUS) begin
      it.kind = K_PLUS;
    end else if (ch >= CH_0 && ch <= CH_9) begin
      it.kind  = K_DIGIT;
      it.digit = DIGIT_W'(ch - CH_0);
    end else if (ch >= CH_LA && ch <= CH_LZ) begin
      it.kind  = K_DIGIT;
      it.digit = DIGIT_W'(ch - CH_LA + LETTER_BASE);
    end else if (ch >= CH_UA && ch <= CH_UZ) begin
      it.kind  = K_DIGIT;
      it.digit = DIGIT_W'(ch - CH_UA + LETTER_BASE);
    end
    return it;
  endfunction

  // Ready is queue space
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign q_item    = classify(in_tdata, in_tlast);

endmodule

### sv/rs2u_fifo.sv
// Small register queue between the front and back ends.
`timescale 1ns / 1ps
module rs2u_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [Width-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output logic [Width-1:0] pop_data
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_r [Depth];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CW'(Depth));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(Depth - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(Depth - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### sv/rs2u_back.sv
// Back end: per-string accumulation, error tracking and the result register.
`timescale 1ns / 1ps
module rs2u_back (
  input  logic            clk,
  input  logic            rst_n,
  input  rs2u_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  rs2u_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [71:0]     out_tdata   // [63:0] value, [64] negative, [67:65] status
);
  import rs2u_pkg::*;

  localparam int PW = VALUE_W + DIGIT_W;   // product width
  localparam int SW = PW + 1;              // product plus digit

  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic               minus_r, minus_nxt;
  logic               first_r, first_nxt;
  logic               digit_r, digit_nxt;
  logic               stop_r, stop_nxt;
  status_t            err_r, err_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_acc_r, out_acc_nxt;
  logic               out_neg_r, out_neg_nxt;
  status_t            out_status_r, out_status_nxt;

  logic               radix_bad;
  logic [PW-1:0]      prod;
  logic [SW-1:0]      sum;
  logic               ovf;
  status_t            status;
  logic [VALUE_W-1:0] value;

  assign radix_bad = (cfg.radix < RADIX_MIN) || (cfg.radix > RADIX_MAX);
  assign prod      = PW'(acc_r) * PW'(cfg.radix);
  assign sum       = SW'(prod) + SW'(q_item.digit);
  assign ovf       = |sum[SW-1:VALUE_W];
  assign q_pop     = q_valid && (!out_valid_r || out_tready);

  always_comb begin
    acc_nxt        = acc_r;
    minus_nxt      = minus_r;
    first_nxt      = first_r;
    digit_nxt      = digit_r;
    stop_nxt       = stop_r;
    err_nxt        = err_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_acc_nxt    = out_acc_r;
    out_neg_nxt    = out_neg_r;
    out_status_nxt = out_status_r;
    status         = ST_OK;

    if (q_pop) begin
      if (radix_bad) begin
        err_nxt = ST_BAD_DIGIT;
      end else if (!stop_r && err_r == ST_OK) begin
        if (q_item.kind == K_NUL) begin
          stop_nxt = 1'b1;
        end else begin
          first_nxt = 1'b0;
          if (first_r && q_item.kind == K_MINUS) begin
            minus_nxt = 1'b1;
          end else if (first_r && q_item.kind == K_PLUS) begin
            minus_nxt = minus_r;
          end else if (q_item.kind != K_DIGIT) begin
            err_nxt = ST_BAD_CHAR;
          end else begin
            digit_nxt = 1'b1;
            if (q_item.digit >= cfg.radix) begin
              err_nxt = ST_BAD_DIGIT;
            end else if (ovf) begin
              err_nxt = ST_OVERFLOW;
            end else begin
              acc_nxt = sum[VALUE_W-1:0];
            end
          end
        end
      end

      // Close the string: build the result and clear the string state
      if (q_item.last) begin
        status = err_nxt;
        if (status == ST_OK && !digit_nxt) begin
          status = ST_EMPTY;
        end
        if (status == ST_OK && minus_nxt && cfg.unsigned_only) begin
          status = ST_BAD_CHAR;
        end
        out_valid_nxt  = 1'b1;
        out_acc_nxt    = acc_nxt;
        out_neg_nxt    = minus_nxt && (status == ST_OK);
        out_status_nxt = status;
        acc_nxt        = '0;
        minus_nxt      = 1'b0;
        first_nxt      = 1'b1;
        digit_nxt      = 1'b0;
        stop_nxt       = 1'b0;
        err_nxt        = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      minus_r     <= 1'b0;
      first_r     <= 1'b1;
      digit_r     <= 1'b0;
      stop_r      <= 1'b0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      minus_r     <= minus_nxt;
      first_r     <= first_nxt;
      digit_r     <= digit_nxt;
      stop_r      <= stop_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_acc_r    <= out_acc_nxt;
    out_neg_r    <= out_neg_nxt;
    out_status_r <= out_status_nxt;
  end

  // Negate on the way out; errors read as zero
  always_comb begin
    value = '0;
    if (out_status_r == ST_OK) begin
      value = out_neg_r ? (~out_acc_r + VALUE_W'(1)) : out_acc_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_status_r, out_neg_r, value};

endmodule

### sv/radix_string_to_uint64.sv
// Top level of the radix string to uint64 converter.
`timescale 1ns / 1ps
// Usage:
//   in_*   : one string byte per transfer in in_tdata[7:0]; in_tlast marks the
//            final byte of a string. A NUL byte ends the string early and the
//            bytes after it are dropped until in_tlast.
//   out_*  : one result per string, issued for the byte with in_tlast:
//            out_tdata[63:0] value, [64] negative, [67:65] status
//            (0 ok, 1 invalid char, 2 digit >= radix or bad radix, 3 overflow, 4 empty).
//   cfg_*  : index 0 = radix (2..36, reset 10), index 1 = unsigned_only (reset 1).
//            Write only while no string is in flight.
// Throughput: one byte per cycle while the output is not stalled, set by the
//   combinational multiply-add of the accumulator by the radix in the back end.
// Result path: a last byte is written into the queue when it transfers, then
//   popped from the queue straight into the output register, which raises
//   out_tvalid.
// Reset: synchronous, active low; clears the queue, the string state and the
//   output valid, and returns radix and unsigned_only to their defaults.
// Stall: while out_tready is low the result holds; the queue keeps taking
//   bytes until it is full, then in_tready drops.
module radix_string_to_uint64 #(
  parameter int QueueDepth = rs2u_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // Byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] ch
  input  logic        in_tlast,
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,   // [63:0] value, [64] negative, [67:65] status, rest zero
  // Configuration writes
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [5:0]  cfg_wdata
);
  import rs2u_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  item_t push_item, pop_item;
  logic  q_push, q_full, q_pop, q_valid;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_RADIX:         cfg_nxt.radix         = cfg_wdata;
        CFG_UNSIGNED_ONLY: cfg_nxt.unsigned_only = cfg_wdata[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radix         <= RADIX_RESET;
      cfg_r.unsigned_only <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Classify incoming bytes
  rs2u_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  // Decouple front and back so each can stall on its own
  rs2u_fifo #(
    .Width ($bits(item_t)),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (pop_item)
  );

  // Accumulate and issue results
  rs2u_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (pop_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### tb/tb_top.sv
// Self-checking testbench for the radix string to uint64 converter.
`timescale 1ns / 1ps
module tb_top;
  import rs2u_pkg::*;

  localparam int          HALF_PERIOD  = 2;
  localparam int          RESET_CYCLES = 2;
  localparam int          DRAIN_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT  = 200_000;

  // One converted string as it leaves the block
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               negative;
    status_t            status;
  } conv_result_t;

  // DUT ports; every input holds a known value from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;      // [7:0] ch
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;          // [63:0] value, [64] negative, [67:65] status, [71:68] zero
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [5:0]  cfg_wdata = '0;

  // Shadow of the converter: register copies and per-string state
  logic [DIGIT_W-1:0] cur_radix = RADIX_RESET;
  logic               cur_unsigned_only = 1'b1;
  logic [VALUE_W-1:0] shadow_acc = '0;
  logic               shadow_minus = 1'b0;
  logic               shadow_first = 1'b1;
  logic               shadow_digit = 1'b0;
  logic               shadow_stopped = 1'b0;
  status_t            shadow_err = ST_OK;

  conv_result_t expected_conversions[$];
  conv_result_t head_result;
  logic [7:0]   str_q[$];          // bytes of the string being assembled

  // Traffic shaping and bookkeeping
  int unsigned in_idle_pct = 37;
  int unsigned out_idle_pct = 37;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned live_bytes = 0;
  int unsigned cfg_writes = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned status_count[5] = '{default: 0};

  radix_string_to_uint64 u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d conversions outstanding",
               cycle_count, expected_conversions.size());
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random back-pressure, or a long hold-off when a test requests one.
  // The hold is counted down here so the sender keeps offering meanwhile.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // Compare every result transfer against the oldest outstanding conversion
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_tready) input_stall_cycles++;
      if (out_tvalid && out_tready) begin
        if (expected_conversions.size() == 0) begin
          report_mismatch("result with nothing outstanding", out_tdata[63:0], '0);
        end else begin
          head_result = expected_conversions.pop_front();
          status_count[head_result.status]++;
          if (out_tdata[63:0] !== head_result.value)
            report_mismatch("value", out_tdata[63:0], head_result.value);
          if (out_tdata[64] !== head_result.negative)
            report_mismatch("negative", VALUE_W'(out_tdata[64]),
                            VALUE_W'(head_result.negative));
          if (out_tdata[67:65] !== head_result.status)
            report_mismatch("status", VALUE_W'(out_tdata[67:65]),
                            VALUE_W'(head_result.status));
          if (out_tdata[71:68] !== 4'd0)
            report_mismatch("pad bits", VALUE_W'(out_tdata[71:68]), '0);
        end
      end
    end
  end

  // Advance the shadow by one accepted byte; on the last byte queue the result.
  function automatic void fold_byte(input logic [7:0] ch, input logic last);
    logic               sign_taken;
    logic               is_digit;
    logic [7:0]         d;
    logic [VALUE_W-1:0] all_ones;
    conv_result_t       r;
    sign_taken = 1'b0;
    is_digit   = 1'b1;
    d          = '0;
    all_ones   = '1;
    if (!shadow_stopped) live_bytes++;
    if (cur_radix < RADIX_MIN || cur_radix > RADIX_MAX) begin
      // Bad radix overrides whatever error the string had so far
      shadow_err = ST_BAD_DIGIT;
    end else if (!shadow_stopped && shadow_err == ST_OK) begin
      if (ch == CH_NUL) begin
        shadow_stopped = 1'b1;
      end else begin
        if (shadow_first) begin
          shadow_first = 1'b0;
          if (ch == CH_MINUS) begin
            shadow_minus = 1'b1;
            sign_taken   = 1'b1;
          end else if (ch == CH_PLUS) begin
            sign_taken = 1'b1;
          end
        end
        if (!sign_taken) begin
          if (ch >= CH_0 && ch <= CH_9) d = ch - CH_0;
          else if (ch >= CH_LA && ch <= CH_LZ) d = ch - CH_LA + LETTER_BASE;
          else if (ch >= CH_UA && ch <= CH_UZ) d = ch - CH_UA + LETTER_BASE;
          else is_digit = 1'b0;
          if (!is_digit) begin
            shadow_err = ST_BAD_CHAR;
          end else begin
            shadow_digit = 1'b1;
            if (d >= cur_radix) shadow_err = ST_BAD_DIGIT;
            else if (shadow_acc > (all_ones - d) / cur_radix) shadow_err = ST_OVERFLOW;
            else shadow_acc = shadow_acc * cur_radix + d;
          end
        end
      end
    end
    if (last) begin
      r.status = shadow_err;
      if (r.status == ST_OK && !shadow_digit) r.status = ST_EMPTY;
      if (r.status == ST_OK && shadow_minus && cur_unsigned_only) r.status = ST_BAD_CHAR;
      r.negative = (r.status == ST_OK) && shadow_minus;
      if (r.status != ST_OK) r.value = '0;
      else if (shadow_minus) r.value = '0 - shadow_acc;
      else r.value = shadow_acc;
      expected_conversions.push_back(r);
      shadow_acc     = '0;
      shadow_minus   = 1'b0;
      shadow_first   = 1'b1;
      shadow_digit   = 1'b0;
      shadow_stopped = 1'b0;
      shadow_err     = ST_OK;
    end
  endfunction

  // Offer one byte, with a random gap first; return at the edge of its transfer
  task automatic send_byte(input logic [7:0] ch, input logic last);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    fold_byte(ch, last);
  endtask

  task automatic send_queued();
    foreach (str_q[i]) send_byte(str_q[i], i == str_q.size() - 1);
    str_q.delete();
  endtask

  // Drop valid and wait out every outstanding result plus the pipeline tail
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_conversions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Call only with the block idle; the shadow takes the value at the same edge
  task automatic write_cfg(input logic [0:0] idx, input logic [5:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_RADIX) cur_radix = val;
    else cur_unsigned_only = val[0];
    cfg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Hold spare bits of the flag register random; only bit 0 counts
  task automatic set_config(input logic [5:0] radix, input logic uns_only);
    drain_results();
    write_cfg(CFG_RADIX, radix);
    write_cfg(CFG_UNSIGNED_ONLY, {5'($urandom_range(0, 31)), uns_only});
  endtask

  function automatic logic [7:0] digit_char(input int unsigned d);
    if (d < 10) return CH_0 + 8'(d);
    return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(d) - LETTER_BASE;
  endfunction

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
  endtask

  task automatic queue_number(input logic [VALUE_W-1:0] v, input int unsigned base);
    logic [7:0]         digs[$];
    logic [VALUE_W-1:0] rest;
    rest = v;
    do begin
      digs.push_front(digit_char(32'(rest % base)));
      rest = rest / base;
    end while (rest != 0);
    foreach (digs[i]) str_q.push_back(digs[i]);
  endtask

  // Mostly well-formed numbers with random content, the rest noise
  task automatic queue_random_string();
    int unsigned        kind;
    int unsigned        base;
    int unsigned        n;
    logic [VALUE_W-1:0] all_ones;
    all_ones = '1;
    base = (cur_radix >= RADIX_MIN && cur_radix <= RADIX_MAX) ? cur_radix : 10;
    kind = $urandom_range(0, 99);
    if (kind < 78) begin
      n = $urandom_range(0, 2);
      if (n == 1) str_q.push_back(CH_PLUS);
      else if (n == 2) str_q.push_back(CH_MINUS);
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) str_q.push_back(CH_0);
      if (kind < 45) begin
        queue_number({$urandom, $urandom} >> $urandom_range(0, 63), base);
      end else if (kind < 55) begin
        queue_number(all_ones, base);
      end else if (kind < 63) begin
        // One step past the largest value: overflow right at the boundary
        queue_number(all_ones / base, base);
        n = 32'(all_ones % base);
        if (n + 1 < base) begin
          str_q.push_back(digit_char(n + 1));
        end else begin
          str_q.push_back(digit_char(n));
          str_q.push_back(digit_char(0));
        end
      end else if (kind < 70) begin
        repeat ($urandom_range(1, 70)) str_q.push_back(digit_char($urandom_range(0, base - 1)));
      end else begin
        // Early end of string; trailing junk must be dropped
        queue_number({$urandom, $urandom} >> $urandom_range(0, 63), base);
        str_q.push_back(CH_NUL);
        repeat ($urandom_range(0, 3)) str_q.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      repeat ($urandom_range(1, 6)) begin
        n = $urandom_range(0, 9);
        if (n < 4) str_q.push_back(8'($urandom_range(0, 255)));
        else if (n < 6) str_q.push_back(digit_char($urandom_range(0, 35)));
        else if (n == 6) str_q.push_back(CH_MINUS);
        else if (n == 7) str_q.push_back(CH_PLUS);
        else if (n == 8) str_q.push_back(CH_NUL);
        else str_q.push_back(digit_char($urandom_range(0, base - 1)));
      end
    end
  endtask

  task automatic send_random_bytes(input int unsigned count);
    int unsigned stop_at;
    stop_at = live_bytes + count;
    while (live_bytes < stop_at) begin
      queue_random_string();
      send_queued();
    end
  endtask

  // Signs, empties, early end, invalid bytes and digits, then negatives and a bad radix
  task automatic test_directed();
    queue_text("0");  send_queued();               // smallest value
    queue_text("-5"); send_queued();               // minus rejected in unsigned-only mode
    queue_text("+7"); send_queued();
    queue_text("-");  send_queued();               // sign alone is empty
    queue_text("+");  str_q.push_back(CH_NUL); send_queued();
    str_q.push_back(CH_NUL); queue_text("9"); send_queued();  // NUL first, then ignored
    queue_text("1-"); send_queued();               // sign after the first byte
    queue_text("1a"); send_queued();               // digit not below radix ten
    str_q.push_back(8'hFF); send_queued();         // invalid byte
    set_config(RADIX_MAX, 1'b0);
    queue_text("-zZ"); send_queued();
    set_config(RADIX_MIN, 1'b0);
    queue_text("-1"); send_queued();               // wraps to all ones
    set_config(6'd0, 1'b1);
    queue_text("1"); send_queued();                // radix out of range
  endtask

  // Walk the radix extremes, out-of-range settings, then random bases
  task automatic test_radix_sweep();
    logic [5:0] radix;
    for (int p = 0; p < 14; p++) begin
      case (p)
        0: radix = RADIX_MIN;
        1: radix = RADIX_MAX;
        2: radix = 6'd0;
        3: radix = 6'd1;
        4: radix = RADIX_MAX + 6'd1;
        5: radix = 6'h3F;
        default: radix = 6'($urandom_range(RADIX_MIN, RADIX_MAX));
      endcase
      set_config(radix, p[0]);
      send_random_bytes((p >= 2 && p <= 5) ? 30 : 150);
    end
  endtask

  // Back-to-back transfers on both sides
  task automatic test_full_rate();
    set_config(6'd16, 1'b0);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    send_random_bytes(200);
    in_idle_pct  = 37;
    out_idle_pct = 37;
  endtask

  // Long receiver hold-off while the sender keeps offering: queue fills, input stalls
  task automatic test_output_stall();
    set_config(RADIX_RESET, 1'b0);
    in_idle_pct = 0;
    hold_req    = 400;
    send_random_bytes(150);
    in_idle_pct = 37;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_radix_sweep();
    test_full_rate();
    test_output_stall();
    drain_results();
    $display("%0d live bytes, results: ok %0d, bad char %0d, bad digit %0d, overflow %0d, empty %0d",
             live_bytes, status_count[ST_OK], status_count[ST_BAD_CHAR],
             status_count[ST_BAD_DIGIT], status_count[ST_OVERFLOW], status_count[ST_EMPTY]);
    $display("%0d register writes, %0d cycles of input stall, %0d mismatches",
             cfg_writes, input_stall_cycles, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
